/* hw/rtl/exp_negative_f32_lut64_unit_macros.svh */
// ----------------------------------------------------------------------------
// exp_negative_f32_lut64_unit_macros
// Assertion macros shared by the exp datapath modules.
// ----------------------------------------------------------------------------
`ifndef EXP_NEGATIVE_F32_LUT64_UNIT_MACROS_SVH
`define EXP_NEGATIVE_F32_LUT64_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EXPN_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("expn: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EXPN_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("expn: next-cycle check failed");

`endif

/* hw/rtl/expn_pkg.sv */
// ----------------------------------------------------------------------------
// expn_pkg
// Constants, the exp2(k/64) table and binary32 multiply/add helpers.
// ----------------------------------------------------------------------------
package expn_pkg;

  typedef struct packed {
    logic [31:0] x;
    logic        last;
    logic        kill;
  } item_t;

  localparam logic [31:0] MAGIC_BIAS   = 32'h48400000;
  localparam logic [31:0] MAGIC_BIAS_N = 32'hC8400000;
  localparam logic [31:0] LOG2E        = 32'h3FB8AA3B;
  localparam logic [31:0] LN2_HI_N     = 32'hBF318000;
  localparam logic [31:0] LN2_LO       = 32'h395E8083;
  localparam logic [31:0] COEF_C2      = 32'h3EFFFF85;
  localparam logic [30:0] CUTOFF_MAG   = 31'h42AEAC4F;
  localparam logic [31:0] QNAN         = 32'h7FC00000;
  localparam logic [5:0]  INDEX_MASK   = 6'h3F;

  localparam logic [31:0] EXP2_TAB [64] = '{
    32'h3F800000, 32'h3F8164D2, 32'h3F82CD87, 32'h3F843A29,
    32'h3F85AAC3, 32'h3F871F62, 32'h3F88980F, 32'h3F8A14D5,
    32'h3F8B95C2, 32'h3F8D1ADF, 32'h3F8EA43A, 32'h3F9031DC,
    32'h3F91C3D3, 32'h3F935A2B, 32'h3F94F4F0, 32'h3F96942D,
    32'h3F9837F0, 32'h3F99E046, 32'h3F9B8D3A, 32'h3F9D3EDA,
    32'h3F9EF532, 32'h3FA0B051, 32'h3FA27043, 32'h3FA43516,
    32'h3FA5FED7, 32'h3FA7CD94, 32'h3FA9A15B, 32'h3FAB7A3A,
    32'h3FAD583F, 32'h3FAF3B79, 32'h3FB123F6, 32'h3FB311C4,
    32'h3FB504F3, 32'h3FB6FD92, 32'h3FB8FBAF, 32'h3FBAFF5B,
    32'h3FBD08A4, 32'h3FBF179A, 32'h3FC12C4D, 32'h3FC346CD,
    32'h3FC5672A, 32'h3FC78D75, 32'h3FC9B9BE, 32'h3FCBEC15,
    32'h3FCE248C, 32'h3FD06334, 32'h3FD2A81E, 32'h3FD4F35B,
    32'h3FD744FD, 32'h3FD99D16, 32'h3FDBFBB8, 32'h3FDE60F5,
    32'h3FE0CCDF, 32'h3FE33F89, 32'h3FE5B907, 32'h3FE8396A,
    32'h3FEAC0C7, 32'h3FED4F30, 32'h3FEFE4BA, 32'h3FF28177,
    32'h3FF5257D, 32'h3FF7D0DF, 32'h3FFA83B3, 32'h3FFD3E0C
  };

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  // value = m * 2^e, round to nearest-even, subnormals kept
  function automatic logic [31:0] fp_round_pack(input logic sgn, input logic [50:0] m,
                                                input logic signed [11:0] e);
    logic [5:0]         lead;
    logic signed [11:0] sh;
    logic signed [11:0] alt;
    logic [5:0]         rs;
    logic [50:0]        q0;
    logic [50:0]        mask;
    logic [51:0]        me;
    logic               rbit;
    logic               sticky;
    logic [24:0]        q;
    logic signed [13:0] ep;
    logic [38:0]        tot;
    lead = '0;
    for (int i = 0; i < 51; i++) begin
      if (m[i]) lead = 6'(i);
    end
    sh  = $signed({6'b0, lead}) - 12'sd23;
    alt = -12'sd149 - e;
    if (alt > sh) sh = alt;
    me     = {1'b0, m};
    rbit   = 1'b0;
    sticky = 1'b0;
    mask   = '0;
    if (sh <= 12'sd0) begin
      rs = 6'(-sh);
      q0 = m << rs;
    end else begin
      rs     = (sh > 12'sd52) ? 6'd52 : 6'(sh);
      q0     = m >> rs;
      mask   = (51'(1) << (rs - 6'd1)) - 51'd1;
      rbit   = me[rs - 6'd1];
      sticky = |(m & mask);
    end
    q   = q0[24:0] + 25'(rbit & (sticky | q0[0]));
    ep  = 14'(e) + 14'(sh) + 14'sd149;
    tot = ({25'b0, ep} << 23) + {14'b0, q};
    if (tot >= 39'h7F800000) return {sgn, 31'h7F800000};
    return {sgn, tot[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic              sg;
    logic [7:0]        ea;
    logic [7:0]        eb;
    logic [23:0]       ma;
    logic [23:0]       mb;
    logic [47:0]       prod;
    sg = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
    if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a))) return QNAN;
    if (fp_is_inf(a) || fp_is_inf(b)) return {sg, 31'h7F800000};
    if (fp_is_zero(a) || fp_is_zero(b)) return {sg, 31'd0};
    ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma   = {a[30:23] != 8'd0, a[22:0]};
    mb   = {b[30:23] != 8'd0, b[22:0]};
    prod = ma * mb;
    return fp_round_pack(sg, {3'b0, prod},
                         $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eg;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [5:0]  ds;
    logic [49:0] sfull;
    logic [49:0] sm;
    logic        lost;
    logic [50:0] bigv;
    logic [50:0] smlv;
    logic [50:0] sum;
    logic        sg;
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
    if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) return QNAN;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (a[30:23] < b[30:23]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eg    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = eg - es;
    ds    = (d > 8'd50) ? 6'd50 : 6'(d);
    sfull = {sml[30:23] != 8'd0, sml[22:0], 26'b0};
    sm    = sfull >> ds;
    lost  = |(sfull & ((50'(1) << ds) - 50'd1));
    bigv  = {1'b0, big[30:23] != 8'd0, big[22:0], 26'b0};
    smlv  = {1'b0, sm[49:1], sm[0] | lost};
    if (big[31] == sml[31]) begin
      sum = bigv + smlv;
      sg  = big[31];
    end else if (bigv >= smlv) begin
      sum = bigv - smlv;
      sg  = big[31];
    end else begin
      sum = smlv - bigv;
      sg  = sml[31];
    end
    if (sum == 51'd0) return {a[31] & b[31], 31'd0};
    return fp_round_pack(sg, sum, $signed({4'b0, eg}) - 12'sd176);
  endfunction

endpackage

/* hw/rtl/expn_in_if.sv */
// ----------------------------------------------------------------------------
// expn_in_if
// Operand stream: one binary32 pattern and a batch-end flag per beat.
// ----------------------------------------------------------------------------
interface expn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  logic        end_of_batch;

  modport source (output valid, output x_bits, output end_of_batch, input ready);
  modport sink (input valid, input x_bits, input end_of_batch, output ready);
endinterface

/* hw/rtl/expn_out_if.sv */
// ----------------------------------------------------------------------------
// expn_out_if
// Result stream: exp(x) as binary32 and the copied batch-end flag per beat.
// ----------------------------------------------------------------------------
interface expn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] exp_bits;
  logic        last_result;

  modport source (output valid, output exp_bits, output last_result, input ready);
  modport sink (input valid, input exp_bits, input last_result, output ready);
endinterface

/* hw/rtl/exp_negative_f32_lut64_unit.sv */
// ----------------------------------------------------------------------------
// exp_negative_f32_lut64_unit
// exp(x) for binary32 x <= 0 via a 64-entry exp2 table and a quadratic.
// ----------------------------------------------------------------------------
// Usage:
//   operand carries x_bits (binary32 pattern) and end_of_batch; result carries
//   exp_bits and last_result, one result beat per operand beat, in order.
//   A beat moves when valid and ready are both high at a clock edge.
//   Throughput: one beat per clock while result.ready stays high; the rate is
//   set by the arithmetic pipeline, where no stage chains two float multiplies
//   or adds in series.
//   Path: from operand acceptance to result valid with an empty queue, a beat
//   passes the queue write, eleven arithmetic stages and the output register;
//   the front register loads at the accepting edge itself.
//   Reset (rst, synchronous) empties the front register, the queue and all
//   pipeline valid bits; the table is constant and needs no fill.
//   When the receiver stalls, the arithmetic pipeline holds in place, the
//   queue and the front register soak up QUEUE_DEPTH + 1 more beats, and
//   then operand.ready drops.
// ----------------------------------------------------------------------------
module exp_negative_f32_lut64_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  expn_in_if.sink    operand,
  expn_out_if.source result
);
  import expn_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t head;

  // classify: flag underflow before the arithmetic
  expn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decouple: front and back stall independently
  expn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // compute: reduction, polynomial, rescale, output register
  expn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );
endmodule

/* hw/rtl/expn_front.sv */
// ----------------------------------------------------------------------------
// expn_front
// Accept operands and flag those below the underflow cutoff.
// ----------------------------------------------------------------------------
module expn_front (
  input  logic            clk,
  input  logic            rst,
  expn_in_if.sink         operand,
  input  logic            q_full,
  output logic            push,
  output expn_pkg::item_t push_item
);
  import expn_pkg::*;

  logic  held;
  item_t item;
  logic  below;

  // negative, not NaN, magnitude past the cutoff
  assign below = operand.x_bits[31] && (operand.x_bits[30:0] > CUTOFF_MAG) &&
                 !fp_is_nan(operand.x_bits);

  assign operand.ready = !held || !q_full;
  assign push          = held && !q_full;
  assign push_item     = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (operand.valid && operand.ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (operand.valid && operand.ready) begin
      item.x    <= operand.x_bits;
      item.last <= operand.end_of_batch;
      item.kill <= below;
    end
  end
endmodule

/* hw/rtl/expn_queue.sv */
// ----------------------------------------------------------------------------
// expn_queue
// Small FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`include "exp_negative_f32_lut64_unit_macros.svh"
module expn_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  expn_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output expn_pkg::item_t head
);
  import expn_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `EXPN_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `EXPN_ASSERT_NEXT(a_count_grow, clk, rst, push && !pop, count == $past(count) + 1'b1)
endmodule

/* hw/rtl/expn_back.sv */
// ----------------------------------------------------------------------------
// expn_back
// Eleven-stage binary32 datapath: range reduction, polynomial, rescale.
// ----------------------------------------------------------------------------
`include "exp_negative_f32_lut64_unit_macros.svh"
module expn_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  expn_pkg::item_t head,
  output logic            pop,
  expn_out_if.source      result
);
  import expn_pkg::*;

  localparam int NS = 11;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] x;
    logic [31:0] s;
    logic [31:0] t;
    logic [31:0] m2;
    logic        last;
    logic        kill;
  } stage_t;

  stage_t        st [NS];
  stage_t        nx [NS];
  logic [NS-1:0] vld;
  logic          oval;
  logic [31:0]   obits;
  logic          olast;
  logic          adv;
  logic [5:0]    k;
  logic [31:0]   f;

  // whole back end moves together unless the output beat is stuck
  assign adv = !oval || result.ready;
  assign pop = adv && q_valid;
  assign k   = st[1].acc[5:0] & INDEX_MASK;
  assign f   = fp_add(st[9].acc, st[9].s);

  always_comb begin
    nx[0]      = '0;
    nx[0].x    = head.x;
    nx[0].last = head.last;
    nx[0].kill = head.kill;
    nx[0].acc  = fp_mul(head.x, LOG2E);
    for (int i = 1; i < NS; i++) begin
      nx[i] = st[i-1];
    end
    nx[1].acc  = fp_add(st[0].acc, MAGIC_BIAS);
    nx[2].s    = EXP2_TAB[k] - {9'b0, k, 17'b0} + {st[1].acc[14:0], 17'b0};
    nx[2].acc  = fp_add(st[1].acc, MAGIC_BIAS_N);
    nx[3].acc  = fp_mul(st[2].acc, LN2_HI_N);
    nx[3].m2   = fp_mul(st[2].acc, LN2_LO);
    nx[4].acc  = fp_add(st[3].acc, st[3].x);
    nx[5].acc  = fp_add(st[4].m2, st[4].acc);
    nx[5].t    = nx[5].acc;
    nx[6].acc  = fp_mul(st[5].t, COEF_C2);
    nx[7].acc  = fp_mul(st[6].acc, st[6].t);
    nx[8].acc  = fp_add(st[7].acc, st[7].t);
    nx[9].acc  = fp_mul(st[8].acc, st[8].s);
    nx[10].acc = st[9].kill ? 32'd0 : (fp_is_nan(f) ? QNAN : f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      oval <= 1'b0;
    end else if (adv) begin
      vld  <= {vld[NS-2:0], q_valid};
      oval <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        st[i] <= nx[i];
      end
      obits <= st[NS-1].acc;
      olast <= st[NS-1].last;
    end
  end

  assign result.valid       = oval;
  assign result.exp_bits    = obits;
  assign result.last_result = olast;

  `EXPN_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, vld == $past(vld) && oval)
  `EXPN_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, q_valid)
endmodule
